>>> rtl/interval_min_max_finder_macros.svh
// Assertion macros for the interval minimum and maximum finder.
`ifndef INTERVAL_MIN_MAX_FINDER_MACROS_SVH
`define INTERVAL_MIN_MAX_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define IMMF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMMF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMMF_ASSERT(label, clk, rst_n, prop, msg)
`define IMMF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/immf_pkg.sv
package immf_pkg;

    localparam int PosW = 13;
    localparam logic [63:0] QnanBits = 64'h7FF8000000000000;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusEmpty = 2'd1;
    localparam logic [1:0] StatusNan   = 2'd2;
    localparam logic [1:0] StatusRange = 2'd3;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    localparam logic [0:0] RegNanCheck    = 1'b0;
    localparam logic [0:0] RegSampleCount = 1'b1;

    // A classified command passed from the front part to the back part.
    typedef struct packed {
        logic             is_load;
        logic             walk;      // query that walks the store
        logic [1:0]       status;    // status of a query that does not walk
        logic [PosW-1:0]  first_pos; // load address, or start of the walk
        logic [PosW-1:0]  last_pos;
        logic [63:0]      data;
    } cmd_t;

    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    // Strict IEEE less-than on two non-NaN values; the zeros compare equal.
    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (both_zero)
            return 1'b0;
        else if (a[63] != b[63])
            return a[63];
        else if (a[63])
            return a[62:0] > b[62:0];
        else
            return a[62:0] < b[62:0];
    endfunction

endpackage

>>> rtl/immf_front.sv
module immf_front
    import immf_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_nan_check,
    input  logic [PosW-1:0] cfg_sample_count,
    input  logic            valid,
    output logic            stall,
    input  logic            opcode,
    input  logic [PosW-1:0] address,
    input  logic [63:0]     sample_bits,
    input  logic [PosW-1:0] start_index,
    input  logic [PosW-1:0] stop_index,
    output logic            q_push,
    output cmd_t            q_data,
    input  logic            q_full
);

    logic [PosW:0] count;
    logic [PosW:0] depth_c;

    assign depth_c = (PosW+1)'(STORE_DEPTH);
    // Effective sample count clamped to the store depth.
    assign count = ({1'b0, cfg_sample_count} > depth_c) ? depth_c
                                                         : {1'b0, cfg_sample_count};

    assign stall  = q_full;
    assign q_push = valid && !q_full;

    // Classify the incoming item.
    always_comb
    begin
        q_data = '0;
        q_data.data = sample_bits;
        if (opcode == OpLoad)
        begin
            q_data.is_load = ({1'b0, address} >= (PosW+1)'(1)) &&
                             ({1'b0, address} <= depth_c);
            q_data.first_pos = address;
        end
        else if (start_index == '0 || {1'b0, stop_index} > count)
        begin
            q_data.status = StatusRange;
        end
        else if (stop_index < start_index)
        begin
            q_data.status = StatusEmpty;
        end
        else
        begin
            q_data.walk = 1'b1;
            q_data.first_pos = start_index;
            q_data.last_pos = stop_index;
        end
    end

    logic unused_ok;
    assign unused_ok = cfg_nan_check | clk | rst_n;

endmodule

>>> rtl/immf_queue.sv
`include "interval_min_max_finder_macros.svh"
module immf_queue
    import immf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic not_empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `IMMF_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "queue overflow")
    `IMMF_ASSERT(a_no_underflow, clk, rst_n, pop |-> not_empty, "queue underflow")
    `IMMF_ASSERT(a_fill_range, clk, rst_n, fill_reg != 2'd3, "queue fill out of range")

endmodule

>>> rtl/immf_back.sv
`include "interval_min_max_finder_macros.svh"
module immf_back
    import immf_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_nan_check,
    input  logic            q_valid,
    input  cmd_t            q_data,
    output logic            q_pop,
    output logic            valid,
    input  logic            stall,
    output logic [63:0]     min_bits,
    output logic [63:0]     max_bits,
    output logic [PosW-1:0] min_position,
    output logic [PosW-1:0] max_position,
    output logic [1:0]      status
);

    localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIRST = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    logic [63:0] store_mem [STORE_DEPTH];
    logic [63:0] rd_data_reg;

    state_t          state_reg, state_next;
    logic [PosW-1:0] rd_pos_reg, rd_pos_next;   // position being read
    logic [PosW-1:0] cur_pos_reg, cur_pos_next; // position of rd_data_reg
    logic [PosW-1:0] last_reg, last_next;
    logic [63:0]     mn_reg, mn_next, mx_reg, mx_next;
    logic [PosW-1:0] mnp_reg, mnp_next, mxp_reg, mxp_next;
    logic            nan_seen_reg, nan_seen_next;
    logic            first_nan_reg, first_nan_next;
    logic [1:0]      status_reg, status_next;
    logic            out_valid_reg, out_valid_next;

    logic            mem_rd;
    logic [PosW-1:0] mem_rd_pos;
    logic            mem_wr;
    logic            take;

    assign take = q_valid && (state_reg == ST_IDLE) && !out_valid_reg;
    assign mem_wr = take && q_data.is_load;

    // Sample store, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            store_mem[AddrW'(q_data.first_pos - PosW'(1))] <= q_data.data;
        if (mem_rd)
            rd_data_reg <= store_mem[AddrW'(mem_rd_pos - PosW'(1))];
    end

    // Walk sequencer: one stored sample compared per cycle.
    always_comb
    begin
        state_next     = state_reg;
        rd_pos_next    = rd_pos_reg;
        cur_pos_next   = cur_pos_reg;
        last_next      = last_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        mnp_next       = mnp_reg;
        mxp_next       = mxp_reg;
        nan_seen_next  = nan_seen_reg;
        first_nan_next = first_nan_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && stall;
        q_pop          = 1'b0;
        mem_rd         = 1'b0;
        mem_rd_pos     = rd_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    q_pop = 1'b1;
                    if (q_data.walk)
                    begin
                        mem_rd       = 1'b1;
                        mem_rd_pos   = q_data.first_pos;
                        cur_pos_next = q_data.first_pos;
                        rd_pos_next  = q_data.first_pos + PosW'(1);
                        last_next    = q_data.last_pos;
                        nan_seen_next = 1'b0;
                        state_next   = ST_FIRST;
                    end
                    else if (!q_data.is_load && q_data.first_pos == '0
                             && q_data.status != StatusOk)
                    begin
                        mn_next = QnanBits;
                        mx_next = QnanBits;
                        mnp_next = '0;
                        mxp_next = '0;
                        status_next = q_data.status;
                        first_nan_next = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_FIRST:
            begin
                mn_next  = rd_data_reg;
                mx_next  = rd_data_reg;
                mnp_next = cur_pos_reg;
                mxp_next = cur_pos_reg;
                first_nan_next = is_nan(rd_data_reg);
                if (is_nan(rd_data_reg) || cur_pos_reg == last_reg)
                    state_next = ST_OUT;
                else
                begin
                    mem_rd       = 1'b1;
                    cur_pos_next = rd_pos_reg;
                    rd_pos_next  = rd_pos_reg + PosW'(1);
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (is_nan(rd_data_reg))
                    nan_seen_next = 1'b1;
                else if (fp_lt(rd_data_reg, mn_reg))
                begin
                    mn_next  = rd_data_reg;
                    mnp_next = cur_pos_reg;
                end
                else if (fp_lt(mx_reg, rd_data_reg))
                begin
                    mx_next  = rd_data_reg;
                    mxp_next = cur_pos_reg;
                end
                if (cur_pos_reg == last_reg)
                    state_next = ST_OUT;
                else
                begin
                    mem_rd       = 1'b1;
                    cur_pos_next = rd_pos_reg;
                    rd_pos_next  = rd_pos_reg + PosW'(1);
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    if (first_nan_reg || (nan_seen_reg && cfg_nan_check))
                    begin
                        mn_next = QnanBits;
                        mx_next = QnanBits;
                        status_next = StatusNan;
                    end
                    else
                        status_next = StatusOk;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk datapath registers.
    always_ff @(posedge clk)
    begin
        rd_pos_reg    <= rd_pos_next;
        cur_pos_reg   <= cur_pos_next;
        last_reg      <= last_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        mnp_reg       <= mnp_next;
        mxp_reg       <= mxp_next;
        nan_seen_reg  <= nan_seen_next;
        first_nan_reg <= first_nan_next;
        status_reg    <= status_next;
    end

    assign valid        = out_valid_reg;
    assign min_bits     = mn_reg;
    assign max_bits     = mx_reg;
    assign min_position = mnp_reg;
    assign max_position = mxp_reg;
    assign status       = status_reg;

    `IMMF_ASSERT(a_walk_no_take, clk, rst_n, (state_reg != ST_IDLE) |-> !q_pop, "pop during walk")
    `IMMF_ASSERT(a_nan_value, clk, rst_n, (valid && status == StatusNan) |-> (min_bits == QnanBits && max_bits == QnanBits), "NaN status without quiet NaN")
    `IMMF_ASSERT(a_range_pos, clk, rst_n, (valid && status == StatusRange) |-> (min_position == '0 && max_position == '0), "range error with position")

endmodule

>>> rtl/interval_min_max_finder.sv
// A query's result follows its walk over the interval; range and empty queries give
// their result without a walk; loads give no result.
// A new query or load is taken only once the back part is idle and its last result
// has been accepted; the walk uses the single store read port one sample per cycle.
// Reset: asynchronous, active low; nan_check is 1, sample_count 0, queue empty.
module interval_min_max_finder
    import immf_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [0:0]      cfg_index,
    input  logic [PosW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            opcode,
    input  logic [PosW-1:0] address,
    input  logic [63:0]     sample_bits,
    input  logic [PosW-1:0] start_index,
    input  logic [PosW-1:0] stop_index,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [63:0]     min_bits,
    output logic [63:0]     max_bits,
    output logic [PosW-1:0] min_position,
    output logic [PosW-1:0] max_position,
    output logic [1:0]      status
);

    logic            nan_check_reg;
    logic [PosW-1:0] sample_count_reg;
    logic            q_push, q_full, q_pop, q_not_empty;
    cmd_t            q_in, q_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nan_check_reg    <= 1'b1;
            sample_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                RegNanCheck:    nan_check_reg    <= cfg_data[0];
                RegSampleCount: sample_count_reg <= cfg_data;
                default:        nan_check_reg    <= nan_check_reg;
            endcase
        end
    end

    immf_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_nan_check(nan_check_reg), .cfg_sample_count(sample_count_reg),
        .valid(in_valid), .stall(in_stall),
        .opcode(opcode), .address(address), .sample_bits(sample_bits),
        .start_index(start_index), .stop_index(stop_index),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    immf_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .not_empty(q_not_empty)
    );

    immf_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_nan_check(nan_check_reg),
        .q_valid(q_not_empty), .q_data(q_out), .q_pop(q_pop),
        .valid(out_valid), .stall(out_stall),
        .min_bits(min_bits), .max_bits(max_bits),
        .min_position(min_position), .max_position(max_position),
        .status(status)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import immf_pkg::*;

    localparam int Depth = 4096;
    localparam int IdleLimit = 20000;

    // Directed stimulus row: one input item plus an optional expected result.
    typedef struct {
        logic            op;
        logic [PosW-1:0] addr;
        logic [63:0]     bits;
        logic [PosW-1:0] first;
        logic [PosW-1:0] last;
        logic            typed;
        logic [63:0]     lo;
        logic [63:0]     hi;
        logic [PosW-1:0] lo_pos;
        logic [PosW-1:0] hi_pos;
        logic [1:0]      stat;
    } row_t;

    typedef struct {
        logic [63:0]     lo;
        logic [63:0]     hi;
        logic [PosW-1:0] lo_pos;
        logic [PosW-1:0] hi_pos;
        logic [1:0]      stat;
    } answer_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_write;
    logic [0:0]      cfg_index;
    logic [PosW-1:0] cfg_data;
    logic            in_valid;
    logic            in_stall;
    logic            opcode;
    logic [PosW-1:0] address;
    logic [63:0]     sample_bits;
    logic [PosW-1:0] start_index;
    logic [PosW-1:0] stop_index;
    logic            out_valid;
    logic            out_stall;
    logic [63:0]     min_bits;
    logic [63:0]     max_bits;
    logic [PosW-1:0] min_position;
    logic [PosW-1:0] max_position;
    logic [1:0]      status;

    // Predictor state.
    logic [63:0] store_copy [Depth];
    logic        nan_check_copy;
    logic [PosW-1:0] count_copy;
    answer_t     pending_answers[$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_receiver;

    interval_min_max_finder DUT (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic lower_than(input logic [63:0] a, input logic [63:0] b);
        if (a[62:0] == 63'd0 && b[62:0] == 63'd0)
            return 1'b0;
        if (a[63] != b[63])
            return a[63];
        if (a[63])
            return a[62:0] > b[62:0];
        return a[62:0] < b[62:0];
    endfunction

    function automatic logic nan_pattern(input logic [63:0] b);
        return b[62:52] == 11'h7FF && b[51:0] != 52'd0;
    endfunction

    // Works out the answer to one query from the shadow store.
    function automatic answer_t interval_answer(input logic [PosW-1:0] first,
                                                input logic [PosW-1:0] last);
        answer_t a;
        logic [63:0] v;
        bit nan_seen;
        int lim;
        a = '{QnanBits, QnanBits, '0, '0, StatusOk};
        lim = (count_copy > Depth) ? Depth : count_copy;
        nan_seen = 0;
        if (first == 0 || last > lim)
            a.stat = StatusRange;
        else if (last < first)
            a.stat = StatusEmpty;
        else
        begin
            a.lo_pos = first;
            a.hi_pos = first;
            v = store_copy[first - 1];
            if (nan_pattern(v))
                a.stat = StatusNan;
            else
            begin
                a.lo = v;
                a.hi = v;
                for (int j = first + 1; j <= last; j++)
                begin
                    v = store_copy[j - 1];
                    if (nan_pattern(v))
                        nan_seen = 1;
                    else if (lower_than(v, a.lo))
                    begin
                        a.lo = v;
                        a.lo_pos = PosW'(j);
                    end
                    else if (lower_than(a.hi, v))
                    begin
                        a.hi = v;
                        a.hi_pos = PosW'(j);
                    end
                end
                if (nan_seen && nan_check_copy)
                begin
                    a.lo = QnanBits;
                    a.hi = QnanBits;
                    a.stat = StatusNan;
                end
            end
        end
        return a;
    endfunction

    // Offers one item, waits for its transfer and updates the predictor.
    // Valid stays high after the transfer until the next item or a drain.
    task automatic send_item(input row_t r);
        answer_t a;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= r.op;
        address <= r.addr;
        sample_bits <= r.bits;
        start_index <= r.first;
        stop_index <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.op == OpLoad)
        begin
            if (r.addr >= 1 && r.addr <= Depth)
                store_copy[r.addr - 1] = r.bits;
        end
        else
        begin
            a = interval_answer(r.first, r.last);
            if (r.typed && a != answer_t'{r.lo, r.hi, r.lo_pos, r.hi_pos, r.stat})
                report_mismatch("directed row", {62'd0, a.stat}, {62'd0, r.stat});
            pending_answers.push_back(a);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [PosW-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == RegNanCheck)
            nan_check_copy = val[0];
        else
            count_copy = val;
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] b;
        int pick;
        b = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick == 0)
            b[62:52] = 11'h7FF;
        else if (pick == 1)
            b[62:0] = '0;
        else if (pick < 6)
            b[62:52] = 11'(11'd1020 + $urandom_range(6));
        return b;
    endfunction

    function automatic row_t query_row(input int first, input int last);
        row_t r;
        r = '{OpQuery, '0, '0, PosW'(first), PosW'(last), 1'b0, '0, '0, '0, '0, StatusOk};
        return r;
    endfunction

    function automatic row_t load_row(input int addr, input logic [63:0] bits);
        row_t r;
        r = '{OpLoad, PosW'(addr), bits, PosW'($urandom), PosW'($urandom), 1'b0,
              '0, '0, '0, '0, StatusOk};
        return r;
    endfunction

    // Random part: fill a chunk, then ask about intervals inside the loaded part.
    task automatic random_phase(input int items);
        int base;
        int len;
        int first;
        int last;
        for (int n = 0; n < items;)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_item(load_row($urandom_range(8191), random_double()));
                n++;
            end
            else if ($urandom_range(3) == 0)
            begin
                base = $urandom_range(1, 40);
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_item(load_row(base + k, random_double()));
                n += len;
            end
            else if ($urandom_range(9) == 0)
            begin
                // Stop beyond the store, so the query is always a range error.
                send_item(query_row($urandom_range(8191), $urandom_range(Depth + 1, 8191)));
                n++;
            end
            else
            begin
                first = $urandom_range(1, 52);
                last = ($urandom_range(7) == 0) ? first - 1
                       : first + $urandom_range(0, 52 - first);
                send_item(query_row(first, last));
                n++;
            end
        end
    endtask

    // Receiver stall generation.
    always @(negedge clk)
    begin
        if (!rst_n || hold_receiver)
            out_stall <= hold_receiver;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checking.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("result with no query outstanding");
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (min_bits !== want.lo)
                    report_mismatch("min_bits", min_bits, want.lo);
                if (max_bits !== want.hi)
                    report_mismatch("max_bits", max_bits, want.hi);
                if (min_position !== want.lo_pos)
                    report_mismatch("min_position", 64'(min_position), 64'(want.lo_pos));
                if (max_position !== want.hi_pos)
                    report_mismatch("max_position", 64'(max_position), 64'(want.hi_pos));
                if (status !== want.stat)
                    report_mismatch("status", 64'(status), 64'(want.stat));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        row_t rows[$];
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_receiver = 0;
        nan_check_copy = 1'b1;
        count_copy = '0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OpLoad;
        address = '0;
        sample_bits = '0;
        start_index = '0;
        stop_index = '0;
        out_stall = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A query right after reset is a range error, the count being zero.
        rows.push_back('{OpQuery, '0, '0, 13'd1, 13'd1, 1'b1,
                         QnanBits, QnanBits, '0, '0, StatusRange});
        foreach (rows[i])
            send_item(rows[i]);
        drain();
        write_reg(RegSampleCount, 13'd4096);
        rows.delete();
        rows.push_back(load_row(1, 64'h3FF0000000000000));
        rows.push_back(load_row(2, 64'hBFF0000000000000));
        rows.push_back(load_row(3, 64'h7FF0000000000001));
        rows.push_back(load_row(4, 64'h8000000000000000));
        rows.push_back(load_row(5, 64'h0000000000000000));
        rows.push_back(load_row(6, 64'hFFF0000000000000));
        rows.push_back(load_row(7, 64'h7FF0000000000000));
        rows.push_back(load_row(4096, 64'hFFFFFFFFFFFFFFFF));
        rows.push_back(load_row(4095, 64'h0000000000000001));
        rows.push_back(load_row(0, 64'h1234));
        rows.push_back(load_row(8191, 64'h5678));
        rows.push_back(query_row(1, 2));
        rows.push_back(query_row(1, 7));
        rows.push_back(query_row(3, 5));
        rows.push_back(query_row(4, 5));
        rows.push_back(query_row(4095, 4096));
        rows.push_back(query_row(4096, 4096));
        rows.push_back('{OpQuery, '0, '0, 13'd5, 13'd4, 1'b1,
                         QnanBits, QnanBits, '0, '0, StatusEmpty});
        rows.push_back('{OpQuery, '0, '0, 13'd0, 13'd3, 1'b1,
                         QnanBits, QnanBits, '0, '0, StatusRange});
        rows.push_back('{OpQuery, '0, '0, 13'd1, 13'd8191, 1'b1,
                         QnanBits, QnanBits, '0, '0, StatusRange});
        foreach (rows[i])
            send_item(rows[i]);
        drain();
        write_reg(RegNanCheck, 13'd0);
        send_item(query_row(1, 7));
        send_item(query_row(3, 5));
        drain();

        // Fill the low part so that every random query reads written entries.
        for (int k = 1; k <= 52; k++)
            send_item(load_row(k, random_double()));
        drain();
        write_reg(RegSampleCount, 13'd8191);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(500);
        drain();
        write_reg(RegNanCheck, 13'd1);
        write_reg(RegSampleCount, 13'd40);
        send_idle_pct = 76;
        random_phase(400);

        // Long receiver hold-off while queries keep coming.
        drain();
        hold_receiver = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_receiver = 0;
            end
            random_phase(60);
        join
        drain();
        write_reg(RegSampleCount, 13'd52);
        send_idle_pct = 0;
        recv_idle_pct = 76;
        random_phase(500);
        drain();
        write_reg(RegNanCheck, 13'd0);
        send_idle_pct = 38;
        recv_idle_pct = 38;
        random_phase(500);
        drain();
        repeat (50) @(negedge clk);

        if (errors == 0 && pending_answers.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
